// ===== src/mkp_pkg.sv =====
// Shared types and constants of the KLV header parser.
`timescale 1ns / 1ps
package mkp_pkg;

  localparam int NUM_FIELDS = 15;
  localparam int FID_W      = 4;
  localparam int VAL_W      = 64;
  localparam int TDATA_W    = 72;

  localparam logic [20:0] SKIP_LIMIT = 21'd1048576;
  localparam logic [16:0] EC_BASE    = 17'd84;

  localparam logic [0:0] REG_SCAN_LIMIT     = 1'd0;
  localparam logic [0:0] REG_MAX_SET_LENGTH = 1'd1;

  localparam logic [FID_W-1:0] FID_STATUS   = 4'd0;
  localparam logic [FID_W-1:0] FID_PIC_PRES = 4'd2;
  localparam logic [FID_W-1:0] FID_PIC_TYPE = 4'd3;
  localparam logic [FID_W-1:0] FID_PIC_BASE = 4'd4;
  localparam logic [FID_W-1:0] FID_SND_PRES = 4'd10;
  localparam logic [FID_W-1:0] FID_SND_BASE = 4'd11;
  localparam logic [FID_W-1:0] FID_LAST     = 4'd14;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_TOO_SMALL = 3'd1,
    ST_BAD_UL    = 3'd2,
    ST_NOT_PP    = 3'd3,
    ST_BAD_LEN   = 3'd4,
    ST_TRUNC     = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    EK_UNKNOWN = 3'd0,
    EK_J2K     = 3'd1,
    EK_PCM     = 3'd2,
    EK_MPEG2   = 3'd3,
    EK_TT      = 3'd4
  } essence_t;

  typedef enum logic [3:0] {
    PH_PKEY  = 4'd0,
    PH_PLEN0 = 4'd1,
    PH_PLENN = 4'd2,
    PH_PACK  = 4'd3,
    PH_KKEY  = 4'd4,
    PH_KLEN0 = 4'd5,
    PH_KLENN = 4'd6,
    PH_SET   = 4'd7,
    PH_SKIP  = 4'd8,
    PH_DONE  = 4'd9
  } phase_t;

  localparam logic [15:0] TAG_WIDTH   = 16'h3203;
  localparam logic [15:0] TAG_HEIGHT  = 16'h3202;
  localparam logic [15:0] TAG_RATE    = 16'h3001;
  localparam logic [15:0] TAG_DUR     = 16'h3002;
  localparam logic [15:0] TAG_DEPTH   = 16'h3301;
  localparam logic [15:0] TAG_AUDRATE = 16'h3D01;
  localparam logic [15:0] TAG_CHANS   = 16'h3D07;

  typedef logic [NUM_FIELDS-1:0][VAL_W-1:0] report_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_status_t;

  function automatic logic [7:0] ul_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h06;
      2'd1:    r = 8'h0e;
      2'd2:    r = 8'h2b;
      default: r = 8'h34;
    endcase
    return r;
  endfunction

  function automatic logic [7:0] pp_byte(input logic [1:0] idx);
    logic [7:0] r;
    case (idx)
      2'd0:    r = 8'h02;
      2'd1:    r = 8'h05;
      default: r = 8'h01;
    endcase
    return r;
  endfunction

  function automatic essence_t classify(input logic [15:0] lbl);
    essence_t r;
    r = EK_UNKNOWN;
    if (lbl[15:8] == 8'h02) begin
      case (lbl[7:0])
        8'h0c:   r = EK_J2K;
        8'h06:   r = EK_PCM;
        8'h04:   r = EK_MPEG2;
        8'h0d:   r = EK_TT;
        default: r = EK_UNKNOWN;
      endcase
    end
    return r;
  endfunction

endpackage

// ===== src/mkp_front.sv =====
// Byte parser: walks partition pack and KLV triplets, builds the report record.
`timescale 1ns / 1ps
module mkp_front import mkp_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        take,
  input  logic [7:0]  data_byte,
  input  logic        last_byte,
  input  logic [23:0] scan_limit,
  input  logic [16:0] max_set_length,
  output logic        push,
  output report_t     report
);

  phase_t      phase, phase_next;
  logic [16:0] fbc, fbc_next;
  logic [63:0] acc, acc_next;
  logic [3:0]  ber_left, ber_left_next;
  logic [3:0]  kf, kf_next;
  logic [15:0] label, label_next;
  essence_t    ek, ek_next;
  logic [23:0] fpos, fpos_next;
  logic [23:0] lvp, lvp_next;
  logic [20:0] rem, rem_next;
  logic [16:0] set_rem, set_rem_next;
  logic [15:0] tag, tag_next;
  logic [15:0] elen, elen_next;
  logic [15:0] eleft, eleft_next;
  logic [63:0] vc, vc_next;
  logic        broken, broken_next;
  logic [5:0][63:0] staged, staged_next;
  report_t     comm, comm_next;

  logic        rep;
  status_t     status;

  always_comb begin
    logic        ber_done;
    logic        apply;
    logic [3:0]  n;
    logic [63:0] first4;
    logic [31:0] a32;
    phase_next    = phase;
    fbc_next      = fbc;
    acc_next      = acc;
    ber_left_next = ber_left;
    kf_next       = kf;
    label_next    = label;
    ek_next       = ek;
    fpos_next     = fpos;
    lvp_next      = lvp;
    rem_next      = rem;
    set_rem_next  = set_rem;
    tag_next      = tag;
    elen_next     = elen;
    eleft_next    = eleft;
    vc_next       = vc;
    broken_next   = broken;
    staged_next   = staged;
    comm_next     = comm;
    rep           = 1'b0;
    status        = ST_OK;
    ber_done      = 1'b0;
    apply         = 1'b0;
    n             = 4'd0;
    first4        = '0;
    a32           = '0;

    if (take && phase != PH_DONE) begin
      if (fpos != 24'hffffff) fpos_next = fpos + 24'd1;
      fbc_next = fbc + 17'd1;
      // BER length decode shared by pack and KLV lengths
      if (phase == PH_PLEN0 || phase == PH_KLEN0) begin
        acc_next = '0;
        if (!data_byte[7]) begin
          acc_next = {56'd0, data_byte};
          ber_done = 1'b1;
        end else if (data_byte[6:0] == 7'd0 || data_byte[6:0] > 7'd8) begin
          ber_left_next = '0;
          ber_done      = 1'b1;
        end else begin
          ber_left_next = data_byte[3:0];
        end
      end else begin
        acc_next      = {acc[55:0], data_byte};
        ber_left_next = ber_left - 4'd1;
        ber_done      = (ber_left == 4'd1);
      end

      case (phase)
        PH_PKEY: begin
          acc_next      = acc;
          ber_left_next = ber_left;
          if (fbc < 17'd4 && data_byte != ul_byte(fbc[1:0])) kf_next[0] = 1'b1;
          if (fbc >= 17'd4 && fbc <= 17'd6 && data_byte != pp_byte(2'(fbc - 17'd4)))
            kf_next[1] = 1'b1;
          if (fbc_next == 17'd16) begin
            if (kf_next[0]) begin
              rep = 1'b1; status = ST_BAD_UL;
            end else if (kf_next[1]) begin
              rep = 1'b1; status = ST_NOT_PP;
            end else begin
              kf_next    = '0;
              phase_next = PH_PLEN0;
            end
          end
        end
        PH_PLEN0, PH_PLENN: begin
          if (!ber_done) begin
            phase_next = PH_PLENN;
          end else if (acc_next == 64'd0 || acc_next > {47'd0, max_set_length}) begin
            rep = 1'b1; status = ST_BAD_LEN;
          end else begin
            rem_next   = 21'(acc_next);
            fbc_next   = '0;
            kf_next    = '0;
            phase_next = PH_PACK;
          end
        end
        PH_PACK: begin
          acc_next      = acc;
          ber_left_next = ber_left;
          if (fbc >= EC_BASE && fbc < EC_BASE + 17'd4 && data_byte != 8'd0) kf_next[0] = 1'b1;
          if (fbc >= EC_BASE + 17'd4 && fbc < EC_BASE + 17'd7 && data_byte != 8'd0)
            kf_next[1] = 1'b1;
          if (fbc == EC_BASE + 17'd7 && data_byte != 8'd16) kf_next[1] = 1'b1;
          if (fbc == EC_BASE + 17'd20) label_next[15:8] = data_byte;
          if (fbc == EC_BASE + 17'd21) label_next[7:0] = data_byte;
          rem_next = rem - 21'd1;
          if (rem_next == 21'd0) begin
            if (fbc_next >= EC_BASE + 17'd24 && kf_next[0] && !kf_next[1])
              ek_next = classify(label_next);
            if (lvp >= scan_limit) begin
              rep = 1'b1;
            end else begin
              phase_next = PH_KKEY; fbc_next = '0; kf_next = '0;
            end
          end
        end
        PH_KKEY: begin
          acc_next      = acc;
          ber_left_next = ber_left;
          if (fbc < 17'd4 && data_byte != ul_byte(fbc[1:0])) kf_next[0] = 1'b1;
          if (fbc == 17'd4 && data_byte != 8'h02) kf_next[0] = 1'b1;
          if (fbc == 17'd5 && data_byte != 8'h53) kf_next[0] = 1'b1;
          if (fbc == 17'd13 && (data_byte == 8'h28 || data_byte == 8'h29)) kf_next[2] = 1'b1;
          if (fbc == 17'd13 && (data_byte == 8'h42 || data_byte == 8'h48)) kf_next[3] = 1'b1;
          if (fbc_next >= 17'd16) phase_next = PH_KLEN0;
        end
        PH_KLEN0, PH_KLENN: begin
          fbc_next = fbc;
          if (!ber_done) begin
            phase_next = PH_KLENN;
          end else if (acc_next == 64'd0) begin
            rep = 1'b1;
          end else begin
            lvp_next = fpos_next;
            if (!kf[0] && (kf[2] || kf[3]) && acc_next <= {47'd0, max_set_length}) begin
              staged_next  = '0;
              set_rem_next = 17'(acc_next);
              fbc_next     = '0;
              acc_next     = '0;
              eleft_next   = '0;
              vc_next      = '0;
              broken_next  = 1'b0;
              phase_next   = PH_SET;
            end else if (acc_next > {43'd0, SKIP_LIMIT}) begin
              rep = 1'b1;
            end else begin
              rem_next   = 21'(acc_next);
              phase_next = PH_SKIP;
            end
          end
        end
        PH_SET: begin
          acc_next      = acc;
          ber_left_next = ber_left;
          fbc_next      = fbc;
          set_rem_next  = set_rem - 17'd1;
          if (!broken) begin
            if (eleft == 16'd0) begin
              a32      = {acc[23:0], data_byte};
              acc_next = {32'd0, a32};
              fbc_next = fbc + 17'd1;
              if (fbc_next >= 17'd4) begin
                tag_next  = a32[31:16];
                elen_next = a32[15:0];
                fbc_next  = '0;
                vc_next   = '0;
                if ({1'b0, a32[15:0]} > set_rem_next) broken_next = 1'b1;
                else if (a32[15:0] != 16'd0) eleft_next = a32[15:0];
              end
            end else begin
              if (fbc < 17'd8) begin
                vc_next  = {vc[55:0], data_byte};
                fbc_next = fbc + 17'd1;
              end
              eleft_next = eleft - 16'd1;
              if (eleft_next == 16'd0) apply = 1'b1;
            end
          end
          if (apply) begin
            n = (elen >= 16'd8) ? 4'd8 : elen[3:0];
            case (n)
              4'd4:    first4 = {32'd0, vc_next[31:0]};
              4'd5:    first4 = {32'd0, vc_next[39:8]};
              4'd6:    first4 = {32'd0, vc_next[47:16]};
              4'd7:    first4 = {32'd0, vc_next[55:24]};
              4'd8:    first4 = {32'd0, vc_next[63:32]};
              default: first4 = '0;
            endcase
            if (kf[2]) begin
              if (tag == TAG_WIDTH && n >= 4'd4) staged_next[0] = first4;
              else if (tag == TAG_HEIGHT && n >= 4'd4) staged_next[1] = first4;
              else if (tag == TAG_RATE && n >= 4'd8) begin
                staged_next[2] = {32'd0, vc_next[63:32]};
                staged_next[3] = {32'd0, vc_next[31:0]};
              end
              else if (tag == TAG_DUR && n >= 4'd8) staged_next[4] = vc_next;
              else if (tag == TAG_DEPTH && n >= 4'd4) staged_next[5] = first4;
            end else begin
              if (tag == TAG_AUDRATE && n >= 4'd8) staged_next[0] = {32'd0, vc_next[63:32]};
              else if (tag == TAG_CHANS && n >= 4'd4) staged_next[1] = first4;
              else if (tag == TAG_AUDRATE && n >= 4'd4) staged_next[2] = first4;
              else if (tag == TAG_DUR && n >= 4'd8) staged_next[3] = vc_next;
            end
            fbc_next = '0;
            vc_next  = '0;
          end
          if (set_rem_next == 17'd0) begin
            // commit the set now that all its bytes are in
            if (kf[2]) begin
              comm_next[FID_PIC_PRES] = 64'd1;
              comm_next[FID_PIC_TYPE] = (ek != EK_UNKNOWN) ? {61'd0, ek} : 64'd1;
              for (int k = 0; k < 6; k++) comm_next[FID_PIC_BASE + k] = staged_next[k];
            end else begin
              comm_next[FID_SND_PRES] = 64'd1;
              for (int k = 0; k < 4; k++) comm_next[FID_SND_BASE + k] = staged_next[k];
            end
            if (lvp >= scan_limit) begin
              rep = 1'b1;
            end else begin
              phase_next = PH_KKEY; fbc_next = '0; kf_next = '0;
            end
          end
        end
        PH_SKIP: begin
          acc_next      = acc;
          ber_left_next = ber_left;
          fbc_next      = fbc;
          rem_next      = rem - 21'd1;
          if (rem_next == 21'd0) begin
            if (lvp >= scan_limit) begin
              rep = 1'b1;
            end else begin
              phase_next = PH_KKEY; fbc_next = '0; kf_next = '0;
            end
          end
        end
        default: begin
          acc_next      = acc;
          ber_left_next = ber_left;
          fbc_next      = fbc;
        end
      endcase
      if (rep) phase_next = PH_DONE;
    end

    // final byte with parsing still open: report how far it got
    if (take && last_byte && phase != PH_DONE && phase_next != PH_DONE) begin
      rep = 1'b1;
      case (phase_next)
        PH_PKEY:            status = ST_TOO_SMALL;
        PH_PLEN0, PH_PLENN: status = ST_BAD_LEN;
        PH_PACK:            status = ST_TRUNC;
        default:            status = ST_OK;
      endcase
    end
  end

  assign push = rep;

  always_comb begin
    report = comm_next;
    report[FID_STATUS] = {61'd0, status};
  end

  always_ff @(posedge clk) begin
    if (rst || (take && last_byte)) begin
      phase    <= PH_PKEY;
      fbc      <= '0;
      acc      <= '0;
      ber_left <= '0;
      kf       <= '0;
      label    <= '0;
      ek       <= EK_UNKNOWN;
      fpos     <= '0;
      lvp      <= '0;
      rem      <= '0;
      set_rem  <= '0;
      tag      <= '0;
      elen     <= '0;
      eleft    <= '0;
      vc       <= '0;
      broken   <= 1'b0;
      staged   <= '0;
      comm     <= '0;
    end else begin
      phase    <= phase_next;
      fbc      <= fbc_next;
      acc      <= acc_next;
      ber_left <= ber_left_next;
      kf       <= kf_next;
      label    <= label_next;
      ek       <= ek_next;
      fpos     <= fpos_next;
      lvp      <= lvp_next;
      rem      <= rem_next;
      set_rem  <= set_rem_next;
      tag      <= tag_next;
      elen     <= elen_next;
      eleft    <= eleft_next;
      vc       <= vc_next;
      broken   <= broken_next;
      staged   <= staged_next;
      comm     <= comm_next;
    end
  end

endmodule

// ===== src/mkp_queue.sv =====
// Two-entry queue of report records between parser and report emitter.
`timescale 1ns / 1ps
module mkp_queue import mkp_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      push,
  input  report_t   wr_data,
  input  logic      pop,
  output report_t   rd_data,
  output q_status_t status
);

  report_t     slots [2];
  logic        wr_ptr, rd_ptr;
  logic [1:0]  count;

  assign status.full  = (count == 2'd2);
  assign status.empty = (count == 2'd0);
  assign rd_data      = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) slots[wr_ptr] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= '0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== src/mkp_back.sv =====
// Report emitter: sends the fifteen fields of the head record in order.
`timescale 1ns / 1ps
module mkp_back import mkp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  q_status_t          q_status,
  input  report_t            head,
  output logic               pop,
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,
  output logic               m_tlast
);

  logic [FID_W-1:0] idx;

  assign m_tvalid = !q_status.empty;
  assign m_tlast  = (idx == FID_LAST);
  assign m_tdata  = {{(TDATA_W - VAL_W - FID_W){1'b0}}, head[idx], idx};
  assign pop      = m_tvalid && m_tready && m_tlast;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (m_tvalid && m_tready) begin
      idx <= m_tlast ? '0 : idx + 4'd1;
    end
  end

endmodule

// ===== src/mxf_klv_header_parser.sv =====
// Top level of the MXF KLV header parser.
// Usage:
//   s_* takes one file byte per request: s_tdata is the byte, s_tlast marks the
//   last byte of the file, after which the parser restarts for the next file.
//   m_* gives the report: fifteen requests, field id and 64-bit value, with
//   m_tlast on field 14. A report goes out when parsing ends (bad key or length,
//   zero KLV length, oversize skip, scan limit or the last byte).
//   cfg_we/cfg_addr/cfg_wdata write scan_limit (0) and max_set_length (1).
// Throughput: one byte per cycle. A byte that ends parsing places its report
//   in a two-report queue in that cycle; s_tready drops only while both slots
//   are full.
// Output: the report is registered into a queue slot and is sent from there once
//   earlier reports are out; its fields go out one per cycle while m_tready is high.
// Reset: rst clears the parser, the queue and the registers to their defaults.
// Stall: while m_tready is low the current field holds; bytes keep flowing
//   until the queue fills.
`timescale 1ns / 1ps
module mxf_klv_header_parser import mkp_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [7:0]         s_tdata,   // [7:0] data_byte
  input  logic               s_tlast,   // last_byte
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [3:0] field_id, [67:4] field_value, rest zero
  output logic               m_tlast,   // last_field
  input  logic               cfg_we,
  input  logic [0:0]         cfg_addr,
  input  logic [23:0]        cfg_wdata
);

  logic [23:0] scan_limit;
  logic [16:0] max_set_length;
  logic        take, push, pop;
  report_t     wr_rec, head;
  q_status_t   q_status;

  assign s_tready = !q_status.full;
  assign take     = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_limit     <= 24'd1048576;
      max_set_length <= 17'd65536;
    end else if (cfg_we) begin
      case (cfg_addr)
        REG_SCAN_LIMIT:     scan_limit     <= cfg_wdata;
        REG_MAX_SET_LENGTH: max_set_length <= cfg_wdata[16:0];
        default:            scan_limit     <= scan_limit;
      endcase
    end
  end

  mkp_front u_front (
    .clk            (clk),
    .rst            (rst),
    .take           (take),
    .data_byte      (s_tdata),
    .last_byte      (s_tlast),
    .scan_limit     (scan_limit),
    .max_set_length (max_set_length),
    .push           (push),
    .report         (wr_rec)
  );

  mkp_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .wr_data (wr_rec),
    .pop     (pop),
    .rd_data (head),
    .status  (q_status)
  );

  mkp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_status (q_status),
    .head     (head),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  a_tlast_id: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata[3:0] == FID_LAST)
    else $error("tlast on a field other than the last");

  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    push |-> !q_status.full)
    else $error("report pushed into a full queue");

  a_pop_valid: assert property (@(posedge clk) disable iff (rst)
    pop |-> !q_status.empty && m_tlast)
    else $error("queue popped outside the final field");

endmodule

// ===== tb/mxf_klv_header_parser_tb.sv =====
// Self-checking testbench of the MXF KLV header parser: byte streams in, reports checked.
`timescale 1ns / 1ps
module mxf_klv_header_parser_tb;
  import mkp_pkg::*;

  typedef struct {
    logic [7:0] data;
    logic       lst;
  } file_byte_t;

  typedef struct {
    logic [FID_W-1:0] fid;
    logic [VAL_W-1:0] val;
    logic             lst;
  } report_field_t;

  localparam int WATCHDOG_LIMIT = 3000;
  localparam int HOLD_CYCLES    = 400;
  localparam logic [7:0] UL_PRE [4] = '{8'h06, 8'h0e, 8'h2b, 8'h34};
  localparam logic [7:0] PP_KEY [3] = '{8'h02, 8'h05, 8'h01};
  localparam logic [15:0] PIC_TAGS [5] = '{TAG_WIDTH, TAG_HEIGHT, TAG_RATE, TAG_DUR, TAG_DEPTH};
  localparam logic [15:0] SND_TAGS [3] = '{TAG_AUDRATE, TAG_CHANS, TAG_DUR};
  localparam logic [7:0] LABEL_CODES [6] = '{8'h0c, 8'h06, 8'h04, 8'h0d, 8'h07, 8'h00};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [7:0] s_tdata = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [TDATA_W-1:0] m_tdata;
  logic m_tlast;
  logic cfg_we = 1'b0;
  logic [0:0] cfg_addr = '0;
  logic [23:0] cfg_wdata = '0;

  mxf_klv_header_parser u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  file_byte_t    byte_q[$];
  report_field_t report_q[$];
  logic [7:0]    file_buf[$];
  logic [7:0]    set_buf[$];
  int            errors = 0;
  int            tx_idle = 0;
  int            rx_stall = 0;
  bit            hold_go = 1'b0;
  bit            hold_used = 1'b0;
  int            hold_cnt = 0;
  int            quiet_cycles = 0;

  // Predictor state
  logic [23:0] scan_lim;
  logic [16:0] max_set;
  phase_t      ph;
  logic [31:0] fbc;
  logic [63:0] lacc;
  int          ber_left;
  logic [7:0]  kf;
  logic [15:0] lbl;
  logic [2:0]  ek;
  logic [23:0] fpos;
  logic [23:0] lvpos;
  logic [63:0] remain;
  logic [31:0] set_rem;
  logic [15:0] etag;
  logic [15:0] elen;
  logic [15:0] eleft;
  logic [63:0] vcap;
  bit          broken;
  logic [63:0] staged [6];
  logic [63:0] committed [NUM_FIELDS];

  function void parser_clear();
    ph = PH_PKEY;
    fbc = 0; lacc = 0; ber_left = 0; kf = 0; lbl = 0; ek = EK_UNKNOWN;
    fpos = 0; lvpos = 0; remain = 0; set_rem = 0;
    etag = 0; elen = 0; eleft = 0; vcap = 0; broken = 0;
    foreach (staged[k]) staged[k] = 0;
    foreach (committed[k]) committed[k] = 0;
  endfunction

  function bit ber_take(logic [7:0] b, bit first);
    if (first) begin
      lacc = 0;
      if (b < 8'h80) begin
        lacc = b;
        return 1;
      end
      ber_left = b & 8'h7f;
      if (ber_left == 0 || ber_left > 8) begin
        ber_left = 0;
        return 1;
      end
      return 0;
    end
    lacc = (lacc << 8) | b;
    ber_left--;
    return ber_left == 0;
  endfunction

  function bit next_klv();
    if (lvpos >= scan_lim) return 1;
    ph = PH_KKEY;
    fbc = 0;
    kf = 0;
    return 0;
  endfunction

  function void apply_entry();
    int n;
    logic [63:0] first4;
    n = (elen < 8) ? elen : 8;
    first4 = 0;
    if (n >= 4) first4 = (vcap >> ((n - 4) * 8)) & 64'hffffffff;
    if (kf[2]) begin
      if (etag == TAG_WIDTH && n >= 4) staged[0] = first4;
      else if (etag == TAG_HEIGHT && n >= 4) staged[1] = first4;
      else if (etag == TAG_RATE && n >= 8) begin
        staged[2] = vcap[63:32];
        staged[3] = vcap[31:0];
      end
      else if (etag == TAG_DUR && n >= 8) staged[4] = vcap;
      else if (etag == TAG_DEPTH && n >= 4) staged[5] = first4;
    end else begin
      // audio rate tag: long value gives the rate, shorter one the bit depth
      if (etag == TAG_AUDRATE && n >= 8) staged[0] = vcap[63:32];
      else if (etag == TAG_CHANS && n >= 4) staged[1] = first4;
      else if (etag == TAG_AUDRATE && n >= 4) staged[2] = first4;
      else if (etag == TAG_DUR && n >= 8) staged[3] = vcap;
    end
    fbc = 0;
    vcap = 0;
  endfunction

  function void set_byte(logic [7:0] b);
    set_rem--;
    if (broken) return;
    if (eleft == 0) begin
      lacc = ((lacc << 8) | b) & 64'hffffffff;
      fbc++;
      if (fbc < 4) return;
      etag = lacc[31:16];
      elen = lacc[15:0];
      fbc = 0;
      vcap = 0;
      if (elen > set_rem) broken = 1;
      else if (elen == 0) apply_entry();
      else eleft = elen;
      return;
    end
    if (fbc < 8) begin
      vcap = (vcap << 8) | b;
      fbc++;
    end
    eleft--;
    if (eleft == 0) apply_entry();
  endfunction

  function void commit_set();
    if (kf[2]) begin
      committed[FID_PIC_PRES] = 1;
      committed[FID_PIC_TYPE] = (ek != EK_UNKNOWN) ? ek : EK_J2K;
      for (int k = 0; k < 6; k++) committed[FID_PIC_BASE + k] = staged[k];
    end else begin
      committed[FID_SND_PRES] = 1;
      for (int k = 0; k < 4; k++) committed[FID_SND_BASE + k] = staged[k];
    end
  endfunction

  function logic [2:0] label_kind();
    if (lbl[15:8] != 8'h02) return EK_UNKNOWN;
    case (lbl[7:0])
      8'h0c:   return EK_J2K;
      8'h06:   return EK_PCM;
      8'h04:   return EK_MPEG2;
      8'h0d:   return EK_TT;
      default: return EK_UNKNOWN;
    endcase
  endfunction

  function bit parse_byte(logic [7:0] b);
    logic [31:0] i;
    i = fbc;
    case (ph)
      PH_PKEY: begin
        if (i < 4 && b != UL_PRE[i]) kf[0] = 1;
        if (i >= 4 && i <= 6 && b != PP_KEY[i-4]) kf[1] = 1;
        fbc = i + 1;
        if (fbc < 16) return 0;
        if (kf[0]) begin
          committed[FID_STATUS] = ST_BAD_UL;
          return 1;
        end
        if (kf[1]) begin
          committed[FID_STATUS] = ST_NOT_PP;
          return 1;
        end
        kf = 0;
        ph = PH_PLEN0;
        return 0;
      end
      PH_PLEN0, PH_PLENN: begin
        if (!ber_take(b, ph == PH_PLEN0)) begin
          ph = PH_PLENN;
          return 0;
        end
        if (lacc == 0 || lacc > max_set) begin
          committed[FID_STATUS] = ST_BAD_LEN;
          return 1;
        end
        remain = lacc;
        fbc = 0;
        kf = 0;
        ph = PH_PACK;
        return 0;
      end
      PH_PACK: begin
        if (i >= EC_BASE && i < EC_BASE + 4 && b != 0) kf[0] = 1;
        if (i >= EC_BASE + 4 && i < EC_BASE + 7 && b != 0) kf[1] = 1;
        if (i == EC_BASE + 7 && b != 16) kf[1] = 1;
        if (i == EC_BASE + 20) lbl[15:8] = b;
        if (i == EC_BASE + 21) lbl[7:0] = b;
        fbc = i + 1;
        remain--;
        if (remain != 0) return 0;
        if (fbc >= EC_BASE + 24 && kf[0] && !kf[1]) ek = label_kind();
        return next_klv();
      end
      PH_KKEY: begin
        if (i < 4 && b != UL_PRE[i]) kf[0] = 1;
        if (i == 4 && b != 8'h02) kf[0] = 1;
        if (i == 5 && b != 8'h53) kf[0] = 1;
        if (i == 13 && (b == 8'h28 || b == 8'h29)) kf[2] = 1;
        if (i == 13 && (b == 8'h42 || b == 8'h48)) kf[3] = 1;
        fbc = i + 1;
        if (fbc >= 16) ph = PH_KLEN0;
        return 0;
      end
      PH_KLEN0, PH_KLENN: begin
        if (!ber_take(b, ph == PH_KLEN0)) begin
          ph = PH_KLENN;
          return 0;
        end
        if (lacc == 0) return 1;
        lvpos = fpos;
        if (!kf[0] && (kf[2] || kf[3]) && lacc <= max_set) begin
          foreach (staged[k]) staged[k] = 0;
          set_rem = lacc[31:0];
          fbc = 0; lacc = 0; eleft = 0; vcap = 0; broken = 0;
          ph = PH_SET;
          return 0;
        end
        if (lacc > SKIP_LIMIT) return 1;
        remain = lacc;
        ph = PH_SKIP;
        return 0;
      end
      PH_SET: begin
        set_byte(b);
        if (set_rem != 0) return 0;
        commit_set();
        return next_klv();
      end
      PH_SKIP: begin
        remain--;
        if (remain != 0) return 0;
        return next_klv();
      end
      default: return 0;
    endcase
  endfunction

  function void queue_report();
    report_field_t rf;
    for (int k = 0; k < NUM_FIELDS; k++) begin
      rf = '{fid: k, val: committed[k], lst: (k == FID_LAST)};
      report_q.insert(report_q.size(), rf);
    end
    ph = PH_DONE;
  endfunction

  function void predict_byte(logic [7:0] b, logic lst);
    if (ph != PH_DONE) begin
      if (fpos != 24'hffffff) fpos++;
      if (parse_byte(b)) queue_report();
    end
    if (lst) begin
      if (ph != PH_DONE) begin
        if (ph == PH_PKEY) committed[FID_STATUS] = ST_TOO_SMALL;
        else if (ph == PH_PLEN0 || ph == PH_PLENN) committed[FID_STATUS] = ST_BAD_LEN;
        else if (ph == PH_PACK) committed[FID_STATUS] = ST_TRUNC;
        queue_report();
      end
      parser_clear();
    end
  endfunction

  // Sender: hold an offered request until taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        predict_byte(s_tdata, s_tlast);
        void'(byte_q.pop_front());
      end
      if (s_tvalid && !s_tready) begin
        s_tvalid <= 1'b1;
      end else if (byte_q.size() != 0 && $urandom_range(99) >= tx_idle) begin
        s_tvalid <= 1'b1;
        s_tdata  <= byte_q[0].data;
        s_tlast  <= byte_q[0].lst;
      end else begin
        s_tvalid <= 1'b0;
      end
    end
  end

  // Receiver and checker
  always @(posedge clk) begin
    report_field_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      if (m_tvalid && m_tready) begin
        if (report_q.size() == 0) begin
          $display("%0t: unexpected field: expected none, actual id %0d value %h last %b",
                   $time, m_tdata[3:0], m_tdata[67:4], m_tlast);
          errors++;
        end else begin
          want = report_q.pop_front();
          if (m_tdata[3:0] !== want.fid || m_tdata[67:4] !== want.val ||
              m_tdata[TDATA_W-1:68] !== '0 || m_tlast !== want.lst) begin
            $display({"%0t: field mismatch: expected id %0d value %h last %b, ",
                      "actual id %0d value %h last %b"},
                     $time, want.fid, want.val, want.lst, m_tdata[3:0], m_tdata[67:4], m_tlast);
            errors++;
          end
        end
      end
      if (hold_go && !hold_used) begin
        hold_used <= 1'b1;
        hold_cnt  <= HOLD_CYCLES;
        m_tready  <= 1'b0;
      end else if (hold_cnt > 0) begin
        hold_cnt <= hold_cnt - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= ($urandom_range(99) >= rx_stall);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("tb: failure");
        $finish;
      end
    end
  end

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    if (idx == REG_SCAN_LIMIT) scan_lim = val;
    else max_set = val[16:0];
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    wait (byte_q.size() == 0 && !s_tvalid && report_q.size() == 0);
    repeat (40) @(posedge clk);
  endtask

  function automatic void put_byte(logic [7:0] b);
    file_buf.insert(file_buf.size(), b);
  endfunction

  function automatic void put_set_byte(logic [7:0] b);
    set_buf.insert(set_buf.size(), b);
  endfunction

  task automatic flush_file();
    file_byte_t fb;
    foreach (file_buf[k]) begin
      fb = '{data: file_buf[k], lst: (k == file_buf.size() - 1)};
      byte_q.insert(byte_q.size(), fb);
    end
    file_buf.delete();
  endtask

  task automatic put_rand(int n);
    repeat (n) put_byte(8'($urandom_range(255)));
  endtask

  task automatic put_ber(longint unsigned len);
    int n;
    if (len < 128 && $urandom_range(2) != 0) begin
      put_byte(8'(len));
    end else begin
      n = (len < 256) ? 1 : (len < 65536) ? 2 : 3;
      n += $urandom_range(1);
      put_byte(8'(8'h80 | n));
      for (int k = n - 1; k >= 0; k--) put_byte(8'(len >> (8 * k)));
    end
  endtask

  // flaw: 0 none, 1 bad prefix, 2 not a partition pack
  task automatic put_pkey(int flaw);
    logic [7:0] key [16];
    int pos;
    foreach (key[k]) key[k] = 8'($urandom_range(255));
    for (int k = 0; k < 4; k++) key[k] = UL_PRE[k];
    for (int k = 0; k < 3; k++) key[4 + k] = PP_KEY[k];
    if (flaw != 0) begin
      pos = (flaw == 1) ? $urandom_range(3) : $urandom_range(4, 6);
      key[pos] ^= 8'($urandom_range(1, 255));
    end
    foreach (key[k]) put_byte(key[k]);
  endtask

  task automatic put_pack(int len, bit labeled, logic [7:0] code);
    logic [7:0] b;
    for (int i = 0; i < len; i++) begin
      b = 8'($urandom_range(255));
      if (labeled) begin
        if (i == EC_BASE) b = 8'($urandom_range(1, 255));
        if (i >= EC_BASE + 4 && i < EC_BASE + 7) b = 0;
        if (i == EC_BASE + 7) b = 16;
        if (i == EC_BASE + 20) b = ($urandom_range(7) == 0) ? 8'($urandom_range(255)) : 8'h02;
        if (i == EC_BASE + 21) b = code;
      end
      put_byte(b);
    end
  endtask

  // kind: 0 picture, 1 sound, 2 other
  task automatic put_key(int kind);
    put_rand(16);
    for (int k = 0; k < 4; k++) file_buf[file_buf.size() - 16 + k] = UL_PRE[k];
    file_buf[file_buf.size() - 12] = 8'h02;
    file_buf[file_buf.size() - 11] = 8'h53;
    if (kind == 0) file_buf[file_buf.size() - 3] = $urandom_range(1) ? 8'h28 : 8'h29;
    else if (kind == 1) file_buf[file_buf.size() - 3] = $urandom_range(1) ? 8'h42 : 8'h48;
    else file_buf[file_buf.size() - 3] = 8'h30;
    if ($urandom_range(9) == 0) file_buf[file_buf.size() - 16 + $urandom_range(5)] ^= 8'h40;
  endtask

  task automatic add_entry(logic [15:0] tag, int len, int nval);
    put_set_byte(tag[15:8]);
    put_set_byte(tag[7:0]);
    put_set_byte(8'(len >> 8));
    put_set_byte(8'(len));
    repeat (nval) put_set_byte(8'($urandom_range(255)));
  endtask

  task automatic put_set(int kind);
    put_key(kind);
    put_ber(set_buf.size());
    foreach (set_buf[k]) put_byte(set_buf[k]);
    set_buf.delete();
  endtask

  task automatic rand_set(int kind);
    int n;
    int len;
    logic [15:0] tag;
    n = $urandom_range(3);
    repeat (n) begin
      tag = (kind == 0) ? PIC_TAGS[$urandom_range(4)] : SND_TAGS[$urandom_range(2)];
      if ($urandom_range(7) == 0) tag = 16'($urandom_range(16'hffff));
      len = 2 * $urandom_range(4);
      add_entry(tag, len, len);
    end
    if ($urandom_range(5) == 0) add_entry(TAG_WIDTH, 300, $urandom_range(2));
    if ($urandom_range(3) == 0) repeat ($urandom_range(1, 2)) put_set_byte(8'($urandom_range(255)));
    if (set_buf.size() == 0) add_entry(TAG_DEPTH, 4, 4);
    put_set(kind);
  endtask

  task automatic rand_file();
    int pick;
    int plen;
    int len;
    pick = $urandom_range(19);
    if (pick < 2) begin
      put_pkey(pick + 1);
      put_rand($urandom_range(2));
      flush_file();
      return;
    end
    put_pkey(0);
    plen = ($urandom_range(9) == 0) ? $urandom_range(108, 112) : $urandom_range(1, 8);
    if ($urandom_range(19) == 0) begin
      put_ber(0);
      flush_file();
      return;
    end
    put_ber(plen);
    put_pack(plen, plen >= 108 && $urandom_range(3) != 0, LABEL_CODES[$urandom_range(5)]);
    repeat ($urandom_range(1, 2)) begin
      pick = $urandom_range(2);
      if (pick < 2) begin
        rand_set(pick);
      end else begin
        put_key(2);
        len = $urandom_range(1, 6);
        put_ber(len);
        put_rand(len);
      end
    end
    pick = $urandom_range(3);
    if (pick == 0) begin
      put_key($urandom_range(2));
      put_byte(8'h00);
      put_rand($urandom_range(2));
    end else if (pick == 1) begin
      put_key($urandom_range(1));
      put_ber(24);
      put_rand($urandom_range(1, 4));
    end
    flush_file();
  endtask

  task automatic directed_files();
    // too small, bad prefix, not a partition pack (trailing byte ignored)
    put_byte(8'h00);
    flush_file();
    put_pkey(1); flush_file();
    put_pkey(2); put_rand(1); flush_file();
    // truncated length
    put_pkey(0); put_byte(8'h82); put_byte(8'h00); flush_file();
    // short pack, picture and sound sets, zero length ends
    put_pkey(0); put_ber(1); put_pack(1, 0, 8'h00);
    add_entry(TAG_WIDTH, 4, 4); add_entry(TAG_RATE, 8, 8); add_entry(TAG_WIDTH, 0, 0);
    put_set_byte(8'hff);
    put_set(0);
    add_entry(TAG_AUDRATE, 8, 8); add_entry(TAG_AUDRATE, 4, 4);
    put_set(1);
    put_key(2); put_byte(8'h00); flush_file();
  endtask

  initial begin
    scan_lim = 24'd1048576;
    max_set = 17'd65536;
    parser_clear();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    directed_files();
    drain();

    write_reg(REG_SCAN_LIMIT, 24'hffffff);
    write_reg(REG_MAX_SET_LENGTH, 24'd65536);
    tx_idle = 75;
    rand_file();
    drain();

    write_reg(REG_SCAN_LIMIT, 24'd1);
    write_reg(REG_MAX_SET_LENGTH, 24'd1);
    tx_idle = 0;
    rx_stall = 75;
    rand_file();
    drain();

    write_reg(REG_SCAN_LIMIT, 24'd200);
    write_reg(REG_MAX_SET_LENGTH, 24'd40);
    tx_idle = 20;
    rx_stall = 20;
    rand_file();
    drain();

    // long receiver hold-off while single-byte files keep reports coming
    write_reg(REG_SCAN_LIMIT, 24'd1048576);
    write_reg(REG_MAX_SET_LENGTH, 24'd300);
    tx_idle = 0;
    rx_stall = 0;
    repeat (6) begin
      put_byte(8'($urandom_range(255)));
      flush_file();
    end
    hold_go = 1'b1;
    drain();

    if (errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/mkp_pkg.sv
src/mkp_front.sv
src/mkp_queue.sv
src/mkp_back.sv
src/mxf_klv_header_parser.sv
tb/mxf_klv_header_parser_tb.sv
